// ===== hw/rtl/acm_pkg.sv =====
package acm_pkg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         address;
        logic signed [15:0] write_value;
        logic signed [15:0] input_value;
    } acm_in_t;

    typedef struct packed {
        logic [7:0]         pc_now;
        logic signed [15:0] acc_now;
        logic               output_valid;
        logic signed [15:0] output_value;
        logic               input_used;
        logic               halted;
        logic               fault;
    } acm_out_t;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_EXEC    = 2'd2;
    // The remaining encoding only reports the state.
    localparam logic [1:0] CMD_NOP     = 2'd3;

    localparam logic [15:0] OP_ADD  = 16'd1;
    localparam logic [15:0] OP_SUB  = 16'd2;
    localparam logic [15:0] OP_MUL  = 16'd3;
    localparam logic [15:0] OP_DIV  = 16'd4;
    localparam logic [15:0] OP_JMP  = 16'd5;
    localparam logic [15:0] OP_JMPN = 16'd6;
    localparam logic [15:0] OP_JMPP = 16'd7;
    localparam logic [15:0] OP_JMPZ = 16'd8;
    localparam logic [15:0] OP_COPY = 16'd9;
    localparam logic [15:0] OP_LOAD = 16'd10;
    localparam logic [15:0] OP_STOR = 16'd11;
    localparam logic [15:0] OP_IN   = 16'd12;
    localparam logic [15:0] OP_OUT  = 16'd13;
    localparam logic [15:0] OP_STOP = 16'd14;

    // Memory address source selected by the controller.
    typedef enum logic [2:0] {
        AS_PC,
        AS_PC1,
        AS_PC2,
        AS_A1,
        AS_A2,
        AS_CLR,
        AS_WR
    } acm_asel_t;

    // Which register captures the memory read data.
    typedef enum logic [2:0] {
        LD_NONE,
        LD_OP,
        LD_A1,
        LD_A2,
        LD_DATA
    } acm_ld_t;

    // Memory write data source.
    typedef enum logic [1:0] {
        WD_ITEM,
        WD_ACC,
        WD_INPUT,
        WD_DATA
    } acm_wd_t;

    typedef struct packed {
        acm_asel_t asel;
        acm_ld_t   ld;
        logic      mem_we;
        acm_wd_t   wsel;
        logic      clr_mem;
        logic      clr_step;
        logic      restart;
        logic      set_fault;
        logic      exec_alu;
        logic      div_start;
        logic      div_commit;
        logic      jump_commit;
        logic      pc_advance;
        logic      load_item;
        logic      out_emit;
        logic      in_emit;
        logic      res_build;
    } acm_cmd_t;

    typedef struct packed {
        logic [15:0] op;
        logic        fault;
        logic        clr_done;
        logic        a1_ok;
        logic        a2_ok;
        logic        pc_room1;
        logic        pc_room2;
        logic        next_ok;
        logic        take;
        logic        div_zero;
        logic        div_done;
        logic [1:0]  cmd;
        logic        wr_ok;
    } acm_stat_t;

endpackage

// ===== hw/rtl/accumulator_machine_step.sv =====
// Accumulator machine, one command per transfer.
// The input channel (in_valid, in_stall, in_data) carries one command: write a
// memory word, restart the machine, or execute the single instruction at the
// program counter. Every accepted command yields exactly one result transfer
// on the output channel (out_valid, out_stall, out_data) that reports pc, acc,
// output/input activity, halt and fault after the command.
// Each instruction reads its opcode and two operand words, then up to one data
// word, in sequence through the single memory port, which sets the rate; a
// divide then runs in the serial divider. The next command can be taken from
// the cycle in which out_valid rises.
// Only one command executes at a time.
// After reset the memory is cleared, one word per cycle, and in_stall stays
// high during that pass.
// The result sits in an output register; while the receiver stalls, the next
// command is still accepted and worked on, and waits at its result stage
// until the previous transfer completes.
module accumulator_machine_step
    import acm_pkg::*;
#(
    parameter int MEM_WORDS = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  acm_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output acm_out_t out_data
);
    acm_cmd_t  ctl;
    acm_stat_t stat;

    acm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    acm_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .ctl     (ctl),
        .stat    (stat),
        .result  (out_data)
    );
endmodule

// ===== hw/rtl/acm_div.sv =====
module acm_div
    import acm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    logic [15:0] rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic [16:0] trial;
    logic [15:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[14:0], quo_reg[15]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[15] ? 16'(-dividend) : dividend;
            dvs_next  = divisor[15] ? 16'(-divisor) : divisor;
            neg_next  = dividend[15] ^ divisor[15];
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[16])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[14:0], 1'b0};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 16'(-quo_reg) : quo_reg;
endmodule

// ===== hw/rtl/acm_datapath.sv =====
module acm_datapath
    import acm_pkg::*;
#(
    parameter int MEM_WORDS = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  acm_in_t   in_item,
    input  acm_cmd_t  ctl,
    output acm_stat_t stat,
    output acm_out_t  result
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam int PW = AW + 2;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rdata_reg;
    logic [AW-1:0] pc_reg, clr_reg;
    logic [15:0] acc_reg, op_reg, a1_reg, a2_reg, data_reg;
    logic        fault_reg;
    acm_in_t     item_reg;
    logic        outv_reg, inu_reg;
    logic [15:0] outval_reg;
    acm_out_t    res_reg;

    logic [AW-1:0] addr;
    logic [15:0]   wdata;
    logic [PW-1:0] pc_w, next_w;
    logic [31:0]   prod;
    logic [15:0]   quo;
    logic          div_done;
    logic signed [15:0] acc_s;

    function automatic logic addr_ok(input logic [15:0] w);
        return (w[15] == 1'b0) && (32'(w) < 32'(MEM_WORDS));
    endfunction

    always_comb
    begin
        unique case (ctl.asel)
            AS_PC:   addr = pc_reg;
            AS_PC1:  addr = AW'(pc_reg + AW'(1));
            AS_PC2:  addr = AW'(pc_reg + AW'(2));
            AS_A1:   addr = a1_reg[AW-1:0];
            AS_A2:   addr = a2_reg[AW-1:0];
            AS_CLR:  addr = clr_reg;
            AS_WR:   addr = AW'(item_reg.address);
            default: addr = pc_reg;
        endcase
        unique case (ctl.wsel)
            WD_ITEM:  wdata = item_reg.write_value;
            WD_ACC:   wdata = acc_reg;
            WD_INPUT: wdata = item_reg.input_value;
            WD_DATA:  wdata = data_reg;
            default:  wdata = '0;
        endcase
        if (ctl.clr_mem)
            wdata = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign pc_w   = PW'(pc_reg);
    assign next_w = pc_w + ((op_reg == OP_COPY) ? PW'(3) : PW'(2));
    assign acc_s  = acc_reg;
    assign prod   = 32'(acc_reg) * 32'(data_reg);

    acm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (acc_reg),
        .divisor  (data_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            acc_reg   <= '0;
            fault_reg <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            if (ctl.clr_step)
                clr_reg <= AW'(clr_reg + AW'(1));
            if (ctl.restart)
            begin
                pc_reg    <= '0;
                acc_reg   <= '0;
                fault_reg <= 1'b0;
            end
            if (ctl.set_fault)
                fault_reg <= 1'b1;
            if (ctl.exec_alu)
            begin
                priority case (op_reg)
                    OP_ADD:  acc_reg <= acc_reg + data_reg;
                    OP_SUB:  acc_reg <= acc_reg - data_reg;
                    OP_MUL:  acc_reg <= prod[15:0];
                    OP_LOAD: acc_reg <= data_reg;
                    default: acc_reg <= acc_reg;
                endcase
            end
            if (ctl.div_commit)
                acc_reg <= quo;
            if (ctl.jump_commit)
                pc_reg <= stat.take ? a1_reg[AW-1:0] : next_w[AW-1:0];
            if (ctl.pc_advance)
                pc_reg <= next_w[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg   <= in_item;
            outv_reg   <= 1'b0;
            inu_reg    <= 1'b0;
            outval_reg <= '0;
        end
        if (ctl.out_emit)
        begin
            outv_reg   <= 1'b1;
            outval_reg <= data_reg;
        end
        if (ctl.in_emit)
            inu_reg <= 1'b1;
        unique case (ctl.ld)
            LD_OP:   op_reg   <= rdata_reg;
            LD_A1:   a1_reg   <= rdata_reg;
            LD_A2:   a2_reg   <= rdata_reg;
            LD_DATA: data_reg <= rdata_reg;
            default: ;
        endcase
        if (ctl.res_build)
        begin
            res_reg.pc_now       <= 8'(pc_reg);
            res_reg.acc_now      <= acc_reg;
            res_reg.output_valid <= outv_reg;
            res_reg.output_value <= outval_reg;
            res_reg.input_used   <= inu_reg;
            res_reg.halted       <= fault_reg || (rdata_reg == OP_STOP);
            res_reg.fault        <= fault_reg;
        end
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.fault    = fault_reg;
        stat.clr_done = (clr_reg == AW'(MEM_WORDS - 1));
        stat.a1_ok    = addr_ok(a1_reg);
        stat.a2_ok    = addr_ok(a2_reg);
        stat.pc_room1 = (pc_w + PW'(1)) < PW'(MEM_WORDS);
        stat.pc_room2 = (pc_w + PW'(2)) < PW'(MEM_WORDS);
        stat.next_ok  = next_w < PW'(MEM_WORDS);
        priority case (op_reg)
            OP_JMP:  stat.take = 1'b1;
            OP_JMPN: stat.take = acc_s < 0;
            OP_JMPP: stat.take = acc_s > 0;
            OP_JMPZ: stat.take = acc_s == 0;
            default: stat.take = 1'b0;
        endcase
        stat.div_zero = (data_reg == '0);
        stat.div_done = div_done;
        stat.cmd      = item_reg.cmd;
        stat.wr_ok    = 32'(item_reg.address) < 32'(MEM_WORDS);
    end

    assign result = res_reg;
endmodule

// ===== hw/rtl/acm_ctrl.sv =====
module acm_ctrl
    import acm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  acm_stat_t stat,
    output acm_cmd_t  ctl
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_FETCH_OP, S_CHK_OP, S_FETCH_A1,
        S_FETCH_A2, S_DECODE, S_READ_DATA, S_EXECUTE, S_DIV_WAIT,
        S_STATUS_RD, S_STATUS, S_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        ctl        = '0;
        ctl.asel   = AS_PC;
        ctl.ld     = LD_NONE;
        ctl.wsel   = WD_ITEM;
        state_next = state_reg;
        ov_next    = ov_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.asel     = AS_CLR;
                ctl.mem_we   = 1'b1;
                ctl.clr_mem  = 1'b1;
                ctl.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority case (stat.cmd)
                    CMD_WRITE:
                    begin
                        ctl.asel   = AS_WR;
                        ctl.wsel   = WD_ITEM;
                        ctl.mem_we = stat.wr_ok;
                        state_next = S_STATUS_RD;
                    end
                    CMD_RESTART:
                    begin
                        ctl.restart = 1'b1;
                        state_next  = S_STATUS_RD;
                    end
                    CMD_EXEC:
                    begin
                        state_next = stat.fault ? S_STATUS_RD : S_FETCH_OP;
                    end
                    default: state_next = S_STATUS_RD;
                endcase
            end
            S_FETCH_OP:
            begin
                ctl.asel   = AS_PC;
                state_next = S_CHK_OP;
            end
            S_CHK_OP:
            begin
                ctl.ld     = LD_OP;
                ctl.asel   = AS_PC1;
                state_next = S_FETCH_A1;
            end
            S_FETCH_A1:
            begin
                ctl.ld     = LD_A1;
                ctl.asel   = AS_PC2;
                state_next = S_FETCH_A2;
            end
            S_FETCH_A2:
            begin
                ctl.ld     = LD_A2;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                ctl.asel = AS_A1;
                if (stat.op == OP_STOP)
                    state_next = S_STATUS_RD;
                else if (stat.op < OP_ADD || stat.op > OP_STOP || !stat.pc_room1 ||
                         (stat.op == OP_COPY && !stat.pc_room2))
                begin
                    ctl.set_fault = 1'b1;
                    state_next    = S_STATUS_RD;
                end
                else if (stat.op >= OP_JMP && stat.op <= OP_JMPZ)
                begin
                    if ((stat.take && !stat.a1_ok) || (!stat.take && !stat.next_ok))
                        ctl.set_fault = 1'b1;
                    else
                        ctl.jump_commit = 1'b1;
                    state_next = S_STATUS_RD;
                end
                else if (!stat.a1_ok || !stat.next_ok ||
                         (stat.op == OP_COPY && !stat.a2_ok))
                begin
                    ctl.set_fault = 1'b1;
                    state_next    = S_STATUS_RD;
                end
                else
                    state_next = S_READ_DATA;
            end
            S_READ_DATA:
            begin
                ctl.ld     = LD_DATA;
                state_next = S_EXECUTE;
            end
            S_EXECUTE:
            begin
                state_next = S_STATUS_RD;
                priority case (stat.op)
                    OP_DIV:
                    begin
                        if (stat.div_zero)
                            ctl.set_fault = 1'b1;
                        else
                        begin
                            ctl.div_start = 1'b1;
                            state_next    = S_DIV_WAIT;
                        end
                    end
                    OP_COPY:
                    begin
                        ctl.asel       = AS_A2;
                        ctl.wsel       = WD_DATA;
                        ctl.mem_we     = 1'b1;
                        ctl.pc_advance = 1'b1;
                    end
                    OP_STOR:
                    begin
                        ctl.asel       = AS_A1;
                        ctl.wsel       = WD_ACC;
                        ctl.mem_we     = 1'b1;
                        ctl.pc_advance = 1'b1;
                    end
                    OP_IN:
                    begin
                        ctl.asel       = AS_A1;
                        ctl.wsel       = WD_INPUT;
                        ctl.mem_we     = 1'b1;
                        ctl.in_emit    = 1'b1;
                        ctl.pc_advance = 1'b1;
                    end
                    OP_OUT:
                    begin
                        ctl.out_emit   = 1'b1;
                        ctl.pc_advance = 1'b1;
                    end
                    default:
                    begin
                        ctl.exec_alu   = 1'b1;
                        ctl.pc_advance = 1'b1;
                    end
                endcase
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.div_commit = 1'b1;
                    ctl.pc_advance = 1'b1;
                    state_next     = S_STATUS_RD;
                end
            end
            S_STATUS_RD:
            begin
                ctl.asel   = AS_PC;
                state_next = S_STATUS;
            end
            S_STATUS:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ctl.res_build = 1'b1;
                    state_next    = S_SEND;
                end
            end
            S_SEND:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
endmodule

// ===== hw/rtl/acm_checker.sv =====
module acm_checker
    import acm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input acm_out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fault |-> out_data.halted)
        else $error("fault without halt");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.output_valid && out_data.input_used))
        else $error("output and input in one item");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command accepted while busy");
endmodule

bind accumulator_machine_step acm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
